// ===== hdl/fsv_pkg.sv =====
// Shared types, constants and the CRC-32 byte fold for the slot image validator.
// No dependencies.
package fsv_pkg;

  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAGIC       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_VERSION = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_COMMIT_MASK = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SIZE    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SLOT_COUNT  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SLOT        = 3'd1;
  localparam logic [2:0] ST_FAULT       = 3'd2;
  localparam logic [2:0] ST_MAGIC       = 3'd3;
  localparam logic [2:0] ST_VERSION     = 3'd4;
  localparam logic [2:0] ST_UNCOMMITTED = 3'd5;
  localparam logic [2:0] ST_SIZE        = 3'd6;
  localparam logic [2:0] ST_CRC         = 3'd7;

  localparam logic       OP_HEADER = 1'b0;
  localparam logic       OP_BYTE   = 1'b1;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam logic [31:0] MAGIC_RST       = 32'd0;
  localparam logic [7:0]  MAX_VERSION_RST = 8'd1;
  localparam logic [7:0]  COMMIT_MASK_RST = 8'd1;
  localparam logic [23:0] MAX_SIZE_RST    = 24'd120832;
  localparam logic [7:0]  SLOT_COUNT_RST  = 8'd1;

  typedef struct packed {
    logic        operation;
    logic        header_only;
    logic [7:0]  slot_number;
    logic [31:0] header_magic;
    logic [7:0]  header_version;
    logic [7:0]  header_flags;
    logic [23:0] image_length;
    logic [31:0] stored_crc;
    logic [7:0]  image_byte;
    logic        transfer_fault;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] computed_crc;
  } out_item_t;

  typedef struct packed {
    logic [31:0] magic_value;
    logic [7:0]  max_header_version;
    logic [7:0]  committed_mask;
    logic [23:0] max_image_size;
    logic [7:0]  slot_count;
  } cfg_t;

  // reflected CRC-32, one byte, eight shift steps
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== hdl/fsv_cfg_regs.sv =====
// Configuration register file for the slot image validator.
// Depends on fsv_pkg.
module fsv_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [fsv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                cfg_wdata_i,
  output fsv_pkg::cfg_t              cfg_o
);

  fsv_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        fsv_pkg::CFG_MAGIC:       cfg_d.magic_value        = cfg_wdata_i;
        fsv_pkg::CFG_MAX_VERSION: cfg_d.max_header_version = cfg_wdata_i[7:0];
        fsv_pkg::CFG_COMMIT_MASK: cfg_d.committed_mask     = cfg_wdata_i[7:0];
        fsv_pkg::CFG_MAX_SIZE:    cfg_d.max_image_size     = cfg_wdata_i[23:0];
        fsv_pkg::CFG_SLOT_COUNT:  cfg_d.slot_count         = cfg_wdata_i[7:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_value        <= fsv_pkg::MAGIC_RST;
      cfg_q.max_header_version <= fsv_pkg::MAX_VERSION_RST;
      cfg_q.committed_mask     <= fsv_pkg::COMMIT_MASK_RST;
      cfg_q.max_image_size     <= fsv_pkg::MAX_SIZE_RST;
      cfg_q.slot_count         <= fsv_pkg::SLOT_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/fsv_hdr_check.sv =====
// Header field checks in priority order; gives the first failing status.
// Depends on fsv_pkg.
module fsv_hdr_check #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  fsv_pkg::cfg_t     cfg_i,
  input  fsv_pkg::in_item_t item_i,
  output logic              pass_o,
  output logic [2:0]        status_o
);

  logic len_too_wide;

  // lengths that do not fit the byte counter
  assign len_too_wide = (SIZE_BITS < 24) ? |(item_i.image_length >> SIZE_BITS) : 1'b0;

  always_comb begin
    pass_o   = 1'b0;
    status_o = fsv_pkg::ST_OK;
    if (item_i.slot_number >= cfg_i.slot_count) begin
      status_o = fsv_pkg::ST_SLOT;
    end else if (item_i.transfer_fault) begin
      status_o = fsv_pkg::ST_FAULT;
    end else if (item_i.header_magic != cfg_i.magic_value) begin
      status_o = fsv_pkg::ST_MAGIC;
    end else if (item_i.header_version > cfg_i.max_header_version) begin
      status_o = fsv_pkg::ST_VERSION;
    end else if ((item_i.header_flags & cfg_i.committed_mask) == 8'd0) begin
      status_o = fsv_pkg::ST_UNCOMMITTED;
    end else if (item_i.image_length == 24'd0 ||
                 item_i.image_length > cfg_i.max_image_size || len_too_wide) begin
      status_o = fsv_pkg::ST_SIZE;
    end else begin
      pass_o = 1'b1;
    end
  end

endmodule

// ===== hdl/firmware_slot_image_validator.sv =====
// Firmware slot image validator: a header item is checked against the configured
// limits and either reports at once or opens a CRC-32 check over the image bytes
// that follow. Throughput is one item per clock when the output is not stalled; a
// result passes the input register and then the result register, with the
// combinational header compare and the eight-step CRC byte fold between them.
// Output back-pressure stalls the pipe, items that give no result included.
// Depends on fsv_pkg, fsv_cfg_regs and fsv_hdr_check.
module firmware_slot_image_validator #(
  parameter int unsigned SIZE_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fsv_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fsv_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fsv_pkg::out_item_t          out_item_o
);

  localparam int unsigned ExtW = (SIZE_BITS > 24) ? SIZE_BITS : 24;

  fsv_pkg::cfg_t      cfg;
  fsv_pkg::in_item_t  item_q;
  fsv_pkg::out_item_t res, out_q;
  logic               in_vld_q, out_vld_q;
  logic               adv, emit;
  logic               hdr_pass;
  logic [2:0]         hdr_status;

  logic                 checking_q, checking_d;
  logic [31:0]          crc_q, crc_d, exp_q, exp_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic [31:0]          crc_new;
  logic [SIZE_BITS-1:0] left_new;
  logic [ExtW-1:0]      len_ext;

  fsv_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  fsv_hdr_check #(.SIZE_BITS(SIZE_BITS)) u_hdr (
    .cfg_i   (cfg),
    .item_i  (item_q),
    .pass_o  (hdr_pass),
    .status_o(hdr_status)
  );

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  assign len_ext  = ExtW'(item_q.image_length);
  assign crc_new  = fsv_pkg::crc_fold_byte(crc_q, item_q.image_byte);
  assign left_new = left_q - SIZE_BITS'(1);

  always_comb begin
    checking_d       = checking_q;
    crc_d            = crc_q;
    exp_d            = exp_q;
    left_d           = left_q;
    emit             = 1'b0;
    res.status       = fsv_pkg::ST_OK;
    res.computed_crc = 32'd0;
    if (item_q.operation == fsv_pkg::OP_HEADER) begin
      // a header always restarts the check
      checking_d = 1'b0;
      crc_d      = fsv_pkg::CRC_ONES;
      left_d     = '0;
      emit       = 1'b1;
      res.status = hdr_status;
      if (hdr_pass && !item_q.header_only) begin
        emit       = 1'b0;
        checking_d = 1'b1;
        left_d     = len_ext[SIZE_BITS-1:0];
        exp_d      = item_q.stored_crc;
      end
    end else if (checking_q) begin
      if (item_q.transfer_fault) begin
        // faulting byte is not folded in
        checking_d       = 1'b0;
        left_d           = '0;
        emit             = 1'b1;
        res.status       = fsv_pkg::ST_FAULT;
        res.computed_crc = crc_q ^ fsv_pkg::CRC_ONES;
      end else begin
        crc_d  = crc_new;
        left_d = left_new;
        if (left_new == '0) begin
          checking_d       = 1'b0;
          crc_d            = fsv_pkg::CRC_ONES;
          emit             = 1'b1;
          res.computed_crc = crc_new ^ fsv_pkg::CRC_ONES;
          res.status       = ((crc_new ^ fsv_pkg::CRC_ONES) == exp_q) ?
                             fsv_pkg::ST_OK : fsv_pkg::ST_CRC;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      checking_q <= 1'b0;
      crc_q      <= fsv_pkg::CRC_ONES;
      exp_q      <= 32'd0;
      left_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        checking_q <= checking_d;
        crc_q      <= crc_d;
        exp_q      <= exp_d;
        left_q     <= left_d;
      end
      if (adv && emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (adv && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/fsv_checker.sv =====
// Port-level checks for the slot image validator, bound to the top level.
// Depends on fsv_pkg and firmware_slot_image_validator.
module fsv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input fsv_pkg::out_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // header-stage rejects never carry a CRC
  a_hdr_crc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == fsv_pkg::ST_SLOT ||
                    out_item_o.status == fsv_pkg::ST_MAGIC ||
                    out_item_o.status == fsv_pkg::ST_VERSION ||
                    out_item_o.status == fsv_pkg::ST_UNCOMMITTED ||
                    out_item_o.status == fsv_pkg::ST_SIZE)
    |-> out_item_o.computed_crc == 32'd0)
    else $error("header reject with nonzero CRC");

  // a fresh result comes from an item accepted earlier, through the input and result registers
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching accepted item");

endmodule

bind firmware_slot_image_validator fsv_checker u_fsv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
